// ----- sv/daspg_pkg.sv -----
// shared constants and types for the dual axis step pulse generator
package daspg_pkg;

	localparam int TIMER_BITS = 8;
	localparam int STEP_SCALE = 8;
	localparam int BYTE_BITS  = 8;
	localparam int COUNT_BITS = 7;
	localparam int LEFT_BITS  = $clog2(((2 ** COUNT_BITS) - 1) * STEP_SCALE + 1);

	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_LOAD = 1'b1;

	localparam logic [BYTE_BITS-1:0] SPEED_RESET = '1;

	typedef struct packed {
		logic step;
		logic dir;
		logic enable_n;
	} axis_pins_t;

endpackage

// ----- sv/daspg_axis.sv -----
// one axis: timer, toggle count and pin levels, updated once per transaction
module daspg_axis (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              advance,
	input  logic                              cmd,
	input  logic [daspg_pkg::BYTE_BITS-1:0]   cmd_byte,
	output daspg_pkg::axis_pins_t             pins
);
	import daspg_pkg::*;

	logic [TIMER_BITS-1:0] timer_q;
	logic [BYTE_BITS-1:0]  speed_q;
	logic [LEFT_BITS-1:0]  left_q;
	axis_pins_t            pins_q;

	logic [TIMER_BITS-1:0] timer_inc;
	logic                  wrap_step;
	logic [LEFT_BITS-1:0]  load_left;

	assign timer_inc = timer_q + TIMER_BITS'(1);
	assign wrap_step = (timer_inc == '0) && (left_q != '0);
	assign load_left = LEFT_BITS'(cmd_byte[COUNT_BITS-1:0]) * LEFT_BITS'(STEP_SCALE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timer_q         <= '0;
			speed_q         <= SPEED_RESET;
			left_q          <= '0;
			pins_q.step     <= 1'b0;
			pins_q.dir      <= 1'b0;
			pins_q.enable_n <= 1'b1;
		end else if (advance) begin
			unique case (cmd)
				CMD_LOAD: begin
					speed_q         <= cmd_byte;
					pins_q.dir      <= cmd_byte[BYTE_BITS-1];
					left_q          <= load_left;
					pins_q.enable_n <= 1'b0;
				end
				CMD_TICK: begin
					if (wrap_step) begin
						pins_q.step <= ~pins_q.step;
						left_q      <= left_q - LEFT_BITS'(1);
						if (left_q == LEFT_BITS'(1)) begin
							pins_q.enable_n <= 1'b1;
						end
						// all ones minus speed, modulo the timer width
						timer_q <= ~TIMER_BITS'(speed_q);
					end else begin
						timer_q <= timer_inc;
					end
				end
				default: begin
					timer_q <= timer_q;
				end
			endcase
		end
	end

	assign pins = pins_q;

endmodule

// ----- sv/dual_axis_step_pulse_generator_core.sv -----
// dual axis step pulse generator: input register, then per-axis update into the pin registers
// throughput: one transaction per cycle, unless a finished result is held by out_stall
// the input stage stalls only while a finished result waits on out_stall
// reset: timers 0, speed bytes 255, counts 0, step and dir pins low, enables high
// nothing is valid after reset until the first input transaction
module dual_axis_step_pulse_generator_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            cmd,
	input  logic [daspg_pkg::BYTE_BITS-1:0] x_byte,
	input  logic [daspg_pkg::BYTE_BITS-1:0] y_byte,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            x_step,
	output logic                            x_dir,
	output logic                            x_enable_n,
	output logic                            y_step,
	output logic                            y_dir,
	output logic                            y_enable_n
);
	import daspg_pkg::*;

	logic                 valid_s1;
	logic                 cmd_s1;
	logic [BYTE_BITS-1:0] x_byte_s1;
	logic [BYTE_BITS-1:0] y_byte_s1;
	logic                 out_valid_q;
	logic                 advance;
	logic                 in_take;
	axis_pins_t           x_pins;
	axis_pins_t           y_pins;

	// the pin registers double as the result register
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_take) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			cmd_s1    <= cmd;
			x_byte_s1 <= x_byte;
			y_byte_s1 <= y_byte;
		end
	end

	daspg_axis u_x_axis (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.cmd      (cmd_s1),
		.cmd_byte (x_byte_s1),
		.pins     (x_pins)
	);

	daspg_axis u_y_axis (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.cmd      (cmd_s1),
		.cmd_byte (y_byte_s1),
		.pins     (y_pins)
	);

	assign out_valid  = out_valid_q;
	assign x_step     = x_pins.step;
	assign x_dir      = x_pins.dir;
	assign x_enable_n = x_pins.enable_n;
	assign y_step     = y_pins.step;
	assign y_dir      = y_pins.dir;
	assign y_enable_n = y_pins.enable_n;

endmodule
